// ===== sv/dual_stepper_pulse_generator_core_defines.svh =====
// ----------------------------------------------------------------------------
// dual stepper pulse generator assertion macros
// shared property templates for the core checks
// ----------------------------------------------------------------------------
`ifndef DUAL_STEPPER_PULSE_GENERATOR_CORE_DEFINES_SVH
`define DUAL_STEPPER_PULSE_GENERATOR_CORE_DEFINES_SVH

// same-cycle implication
`define DSPG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dspg assertion failed");

// next-cycle implication
`define DSPG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dspg assertion failed");

`endif

// ===== sv/dspg_pkg.sv =====
// ----------------------------------------------------------------------------
// dspg_pkg
// shared constants, codes and control types of the stepper pulse generator
// ----------------------------------------------------------------------------
`default_nettype none

package dspg_pkg;

  localparam int CLK_WIDTH        = 27;
  localparam int TIMEOUT_WIDTH    = 16;
  localparam int CFG_INDEX_WIDTH  = 2;
  localparam int CFG_DATA_WIDTH   = 27;
  localparam int PERIOD_WIDTH_DEF = 32;
  localparam int RATE_WIDTH_DEF   = 17;

  localparam logic [CLK_WIDTH-1:0]     CLK_HZ_RESET      = 27'd42000000;
  localparam logic [TIMEOUT_WIDTH-1:0] TIMEOUT_MS_RESET  = 16'd500;
  localparam logic                     LEFT_REV_RESET    = 1'b1;
  localparam logic                     RIGHT_REV_RESET   = 1'b0;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_COUNTER_CLOCK = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TIMEOUT       = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LEFT_REVERSE  = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RIGHT_REVERSE = 2'd3;

  localparam logic REQ_COMMAND = 1'b0;
  localparam logic REQ_TICK    = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_DIVIDE
  } ctrl_state_t;

  typedef struct packed {
    logic tick;
    logic stop;
    logic div_start;
    logic load;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic rates_nonzero;
    logic div_done;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== sv/dspg_in_if.sv =====
// ----------------------------------------------------------------------------
// dspg_in_if
// input channel: speed commands and counter clock ticks
// ----------------------------------------------------------------------------
`default_nettype none

interface dspg_in_if #(
  parameter int RATE_WIDTH = dspg_pkg::RATE_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic signed [RATE_WIDTH-1:0] left_rate;
  logic signed [RATE_WIDTH-1:0] right_rate;
  logic                         ms_strobe;

  modport source (output valid, output req_type, output left_rate, output right_rate,
                  output ms_strobe, input ready);
  modport sink (input valid, input req_type, input left_rate, input right_rate,
                input ms_strobe, output ready);
endinterface

`default_nettype wire

// ===== sv/dspg_out_if.sv =====
// ----------------------------------------------------------------------------
// dspg_out_if
// result channel: step levels, directions and driver enable
// ----------------------------------------------------------------------------
`default_nettype none

interface dspg_out_if;
  logic valid;
  logic ready;
  logic left_step;
  logic right_step;
  logic left_dir;
  logic right_dir;
  logic drivers_enabled;

  modport source (output valid, output left_step, output right_step, output left_dir,
                  output right_dir, output drivers_enabled, input ready);
  modport sink (input valid, input left_step, input right_step, input left_dir,
                input right_dir, input drivers_enabled, output ready);
endinterface

`default_nettype wire

// ===== sv/dspg_cfg_if.sv =====
// ----------------------------------------------------------------------------
// dspg_cfg_if
// configuration write channel: register index and write data
// ----------------------------------------------------------------------------
`default_nettype none

interface dspg_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [dspg_pkg::CFG_INDEX_WIDTH-1:0] index;
  logic [dspg_pkg::CFG_DATA_WIDTH-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/dspg_div.sv =====
// ----------------------------------------------------------------------------
// dspg_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module dspg_div #(
  parameter int DIVIDEND_W = dspg_pkg::CLK_WIDTH,
  parameter int DIVISOR_W  = dspg_pkg::RATE_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]  divisor,
  output logic                       done,
  output logic [DIVIDEND_W-1:0]      quotient
);

  localparam int CW = $clog2(DIVIDEND_W + 1);

  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  done_r, done_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DIVISOR_W-1:0]  dvs_r, dvs_nxt;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;

  assign trial = {rem_r, quo_r[DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_comb begin
    cnt_nxt  = cnt_r;
    done_nxt = done_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      cnt_nxt  = CW'(DIVIDEND_W);
      done_nxt = 1'b0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - CW'(1);
      if (fits) begin
        rem_nxt = DIVISOR_W'(trial - {1'b0, dvs_r});
      end else begin
        rem_nxt = trial[DIVISOR_W-1:0];
      end
      quo_nxt = {quo_r[DIVIDEND_W-2:0], fits};
      if (cnt_r == CW'(1)) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ===== sv/dspg_ctrl.sv =====
// ----------------------------------------------------------------------------
// dspg_ctrl
// transaction sequencing: accept, period division wait, result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module dspg_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_req_type,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire dspg_pkg::dp_status_t status,
  output dspg_pkg::dp_cmd_t         cmd
);

  dspg_pkg::ctrl_state_t state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_free;
  logic                  accept;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    in_ready      = (state_r == dspg_pkg::ST_IDLE) && out_free;
    accept        = in_valid && in_ready;
    cmd.tick      = accept && (in_req_type == dspg_pkg::REQ_TICK);
    cmd.stop      = accept && (in_req_type == dspg_pkg::REQ_COMMAND) &&
                    !status.rates_nonzero;
    cmd.div_start = accept && (in_req_type == dspg_pkg::REQ_COMMAND) &&
                    status.rates_nonzero;
    cmd.load      = (state_r == dspg_pkg::ST_DIVIDE) && status.div_done && out_free;
    cmd.out_load  = cmd.tick || cmd.stop || cmd.load;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dspg_pkg::ST_IDLE: begin
        if (cmd.div_start) begin
          state_nxt = dspg_pkg::ST_DIVIDE;
        end
      end
      dspg_pkg::ST_DIVIDE: begin
        if (cmd.load) begin
          state_nxt = dspg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dspg_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dspg_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== sv/dspg_dp.sv =====
// ----------------------------------------------------------------------------
// dspg_dp
// configuration registers, period dividers, step counters, watchdog, result
// ----------------------------------------------------------------------------
`default_nettype none

module dspg_dp #(
  parameter int PERIOD_WIDTH = dspg_pkg::PERIOD_WIDTH_DEF,
  parameter int RATE_WIDTH   = dspg_pkg::RATE_WIDTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [dspg_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [dspg_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  input  wire logic signed [RATE_WIDTH-1:0]         left_rate,
  input  wire logic signed [RATE_WIDTH-1:0]         right_rate,
  input  wire logic                                 ms_strobe,
  input  wire dspg_pkg::dp_cmd_t                    cmd,
  output dspg_pkg::dp_status_t                      status,
  output logic                                      left_step,
  output logic                                      right_step,
  output logic                                      left_dir,
  output logic                                      right_dir,
  output logic                                      drivers_enabled
);

  localparam int CLK_W = dspg_pkg::CLK_WIDTH;
  localparam int TMO_W = dspg_pkg::TIMEOUT_WIDTH;

  // configuration
  logic [CLK_W-1:0] clk_hz_r, clk_hz_nxt;
  logic [TMO_W-1:0] timeout_r, timeout_nxt;
  logic             lrev_r, lrev_nxt;
  logic             rrev_r, rrev_nxt;

  // channel state, lane 0 left, lane 1 right
  logic [1:0][PERIOD_WIDTH-1:0] period_r, period_nxt;
  logic [1:0][PERIOD_WIDTH-1:0] count_r, count_nxt;
  logic [1:0]                   level_r, level_nxt;
  logic [1:0]                   dir_r, dir_nxt;
  logic [1:0]                   pend_dir_r, pend_dir_nxt;
  logic                         en_r, en_nxt;
  logic [TMO_W-1:0]             ms_r, ms_nxt;

  logic [4:0] res_r, res_nxt;

  logic [1:0][RATE_WIDTH-1:0]   rate;
  logic [1:0][RATE_WIDTH-1:0]   mag;
  logic [1:0]                   rev;
  logic [1:0]                   rate_dir;
  logic [1:0]                   div_done;
  logic [1:0][CLK_W-1:0]        quo;
  logic [1:0][PERIOD_WIDTH-1:0] quo_sat;
  logic [1:0][PERIOD_WIDTH-1:0] tick_count;
  logic [1:0]                   tick_level;
  logic [TMO_W-1:0]             ms_inc;
  logic                         en_tick;

  assign rate[0] = left_rate;
  assign rate[1] = right_rate;
  assign rev     = {rrev_r, lrev_r};

  for (genvar i = 0; i < 2; i++) begin : g_lane
    logic [PERIOD_WIDTH:0]   cnt_inc;
    logic [PERIOD_WIDTH-1:0] cnt_step;
    logic                    lvl_step;

    assign mag[i]      = rate[i][RATE_WIDTH-1] ? (~rate[i] + RATE_WIDTH'(1)) : rate[i];
    assign rate_dir[i] = ~(rate[i][RATE_WIDTH-1] ^ rev[i]);

    dspg_div #(
      .DIVIDEND_W(CLK_W),
      .DIVISOR_W (RATE_WIDTH)
    ) u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .start   (cmd.div_start),
      .dividend(clk_hz_r),
      .divisor (mag[i]),
      .done    (div_done[i]),
      .quotient(quo[i])
    );

    if (PERIOD_WIDTH >= CLK_W) begin : g_wide
      assign quo_sat[i] = PERIOD_WIDTH'(quo[i]);
    end else begin : g_sat
      assign quo_sat[i] = (|quo[i][CLK_W-1:PERIOD_WIDTH]) ? '1 : quo[i][PERIOD_WIDTH-1:0];
    end

    // wrap and set the level at the period, clear the level at half the period
    assign cnt_inc = {1'b0, count_r[i]} + (PERIOD_WIDTH+1)'(1);
    always_comb begin
      if (cnt_inc >= {1'b0, period_r[i]}) begin
        cnt_step = '0;
        lvl_step = 1'b1;
      end else begin
        cnt_step = cnt_inc[PERIOD_WIDTH-1:0];
        lvl_step = (cnt_inc[PERIOD_WIDTH-1:0] == (period_r[i] >> 1)) ? 1'b0 :
                   level_r[i];
      end
    end

    assign tick_count[i] = cnt_step;
    assign tick_level[i] = lvl_step;
  end

  assign status.rates_nonzero = (|rate[0]) && (|rate[1]);
  assign status.div_done      = &div_done;

  always_comb begin
    clk_hz_nxt  = clk_hz_r;
    timeout_nxt = timeout_r;
    lrev_nxt    = lrev_r;
    rrev_nxt    = rrev_r;
    if (cfg_we) begin
      case (cfg_index)
        dspg_pkg::CFG_COUNTER_CLOCK: clk_hz_nxt  = cfg_data[CLK_W-1:0];
        dspg_pkg::CFG_TIMEOUT:       timeout_nxt = cfg_data[TMO_W-1:0];
        dspg_pkg::CFG_LEFT_REVERSE:  lrev_nxt    = cfg_data[0];
        dspg_pkg::CFG_RIGHT_REVERSE: rrev_nxt    = cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // watchdog age with saturation
  assign ms_inc = (ms_r != '1) ? (ms_r + TMO_W'(1)) : ms_r;

  always_comb begin
    period_nxt   = period_r;
    count_nxt    = count_r;
    level_nxt    = level_r;
    dir_nxt      = dir_r;
    pend_dir_nxt = pend_dir_r;
    en_nxt       = en_r;
    ms_nxt       = ms_r;
    en_tick      = en_r;
    if (cmd.div_start) begin
      pend_dir_nxt = rate_dir;
    end
    if (cmd.stop) begin
      en_nxt = 1'b0;
    end
    if (cmd.load) begin
      period_nxt = quo_sat;
      count_nxt  = '0;
      level_nxt  = '0;
      dir_nxt    = pend_dir_r;
      ms_nxt     = '0;
      en_nxt     = 1'b1;
    end
    if (cmd.tick) begin
      if (en_r && ms_strobe) begin
        ms_nxt = ms_inc;
        if (ms_inc >= timeout_r) begin
          en_tick = 1'b0;
        end
      end
      en_nxt = en_tick;
      if (en_tick) begin
        count_nxt = tick_count;
        level_nxt = tick_level;
      end
    end
  end

  always_comb begin
    res_nxt = res_r;
    if (cmd.out_load) begin
      res_nxt = {en_nxt, dir_nxt[1], dir_nxt[0], en_nxt & level_nxt[1],
                 en_nxt & level_nxt[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_hz_r  <= dspg_pkg::CLK_HZ_RESET;
      timeout_r <= dspg_pkg::TIMEOUT_MS_RESET;
      lrev_r    <= dspg_pkg::LEFT_REV_RESET;
      rrev_r    <= dspg_pkg::RIGHT_REV_RESET;
      period_r  <= '0;
      count_r   <= '0;
      level_r   <= '0;
      dir_r     <= '0;
      en_r      <= 1'b0;
      ms_r      <= '0;
    end else begin
      clk_hz_r  <= clk_hz_nxt;
      timeout_r <= timeout_nxt;
      lrev_r    <= lrev_nxt;
      rrev_r    <= rrev_nxt;
      period_r  <= period_nxt;
      count_r   <= count_nxt;
      level_r   <= level_nxt;
      dir_r     <= dir_nxt;
      en_r      <= en_nxt;
      ms_r      <= ms_nxt;
    end
    pend_dir_r <= pend_dir_nxt;
    res_r      <= res_nxt;
  end

  assign left_step       = res_r[0];
  assign right_step      = res_r[1];
  assign left_dir        = res_r[2];
  assign right_dir       = res_r[3];
  assign drivers_enabled = res_r[4];

endmodule

`default_nettype wire

// ===== sv/dual_stepper_pulse_generator_core.sv =====
// ----------------------------------------------------------------------------
// dual_stepper_pulse_generator_core
// ticks and zero-rate commands: registered result, one transaction per cycle while results are taken
// enabling commands: wait for the bit-serial period dividers, then load the result
// a result not yet taken holds off the next input transaction
// reset (synchronous, active low) clears the internal driver enable and restores config
// ----------------------------------------------------------------------------
`default_nettype none
`include "dual_stepper_pulse_generator_core_defines.svh"

module dual_stepper_pulse_generator_core #(
  parameter int PERIOD_WIDTH = dspg_pkg::PERIOD_WIDTH_DEF,
  parameter int RATE_WIDTH   = dspg_pkg::RATE_WIDTH_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  dspg_in_if.sink  in_chan,
  dspg_out_if.source out_chan,
  dspg_cfg_if.sink cfg_chan
);

  dspg_pkg::dp_cmd_t    cmd;
  dspg_pkg::dp_status_t status;

  assign cfg_chan.ready = 1'b1;

  dspg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_req_type(in_chan.req_type),
    .in_ready   (in_chan.ready),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .status     (status),
    .cmd        (cmd)
  );

  dspg_dp #(
    .PERIOD_WIDTH(PERIOD_WIDTH),
    .RATE_WIDTH  (RATE_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_chan.valid),
    .cfg_index      (cfg_chan.index),
    .cfg_data       (cfg_chan.data),
    .left_rate      (in_chan.left_rate),
    .right_rate     (in_chan.right_rate),
    .ms_strobe      (in_chan.ms_strobe),
    .cmd            (cmd),
    .status         (status),
    .left_step      (out_chan.left_step),
    .right_step     (out_chan.right_step),
    .left_dir       (out_chan.left_dir),
    .right_dir      (out_chan.right_dir),
    .drivers_enabled(out_chan.drivers_enabled)
  );

  `DSPG_ASSERT_IMP(a_left_step_gated, clk, rst_n, out_chan.valid && out_chan.left_step, out_chan.drivers_enabled)
  `DSPG_ASSERT_IMP(a_right_step_gated, clk, rst_n, out_chan.valid && out_chan.right_step, out_chan.drivers_enabled)
  `DSPG_ASSERT_NXT(a_divide_blocks_input, clk, rst_n, cmd.div_start, !in_chan.ready)

endmodule

`default_nettype wire
